>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Clock is clk, reset is rst_n (active low).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FSPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/fspt_pkg.sv
// ----------------------------------------------------------------------------
// fspt_pkg
// Shared constants and types for the floor switch position tracker.
// ----------------------------------------------------------------------------
package fspt_pkg;

  localparam int SAMPLE_FIELDS    = 8;
  localparam int SAMPLES_PER_TICK = 8;
  // samples that take part in the vote, limited to the fields present
  localparam int VOTE_N = (SAMPLES_PER_TICK < 1) ? 1 :
                          (SAMPLES_PER_TICK > SAMPLE_FIELDS) ? SAMPLE_FIELDS :
                          SAMPLES_PER_TICK;
  localparam int CNT_W  = $clog2(VOTE_N + 1);

  localparam int CODE_W  = 2;
  localparam int FLOOR_W = 8;
  localparam int EV_W    = 2;

  // switch codes: bit 1 upper, bit 0 lower
  localparam logic [CODE_W-1:0] CODE_CLEAR = 2'd0;
  localparam logic [CODE_W-1:0] CODE_LOWER = 2'd1;
  localparam logic [CODE_W-1:0] CODE_UPPER = 2'd2;
  localparam logic [CODE_W-1:0] CODE_BOTH  = 2'd3;

  // step events
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_UP   = 2'd1;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd2;

  // configuration register indexes
  localparam logic REG_FILTER_MODE = 1'b0;

  typedef logic [SAMPLE_FIELDS-1:0][CODE_W-1:0] sample_arr_t;

endpackage

>>> rtl/fspt_vote.sv
// ----------------------------------------------------------------------------
// fspt_vote
// Majority vote over one tick's switch samples; the lowest code wins a tie.
// ----------------------------------------------------------------------------
module fspt_vote (
  input  fspt_pkg::sample_arr_t        samples,
  output logic [fspt_pkg::CODE_W-1:0]  vote
);
  import fspt_pkg::*;

  logic [3:0][CNT_W-1:0] cnt;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cnt[c] = '0;
      for (int i = 0; i < VOTE_N; i++) begin
        if (samples[i] == CODE_W'(c)) begin
          cnt[c] = cnt[c] + CNT_W'(1);
        end
      end
    end
  end

  // strict compare keeps the lower code on a tie
  always_comb begin
    vote = CODE_CLEAR;
    for (int c = 1; c < 4; c++) begin
      if (cnt[c] > cnt[vote]) begin
        vote = CODE_W'(c);
      end
    end
  end

endmodule

>>> rtl/floor_switch_position_tracker.sv
// ----------------------------------------------------------------------------
// floor_switch_position_tracker
// Votes each tick's switch samples and tracks the floor count from passages.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid/in_tready   | in_tdata[15:0]: sample0..sample7
//  out_    | master    | out_tvalid/out_tready | out_tdata[15:0]: count, vote, event, armed
//  cfg_    | APB slave | psel/penable, pready  | filter_mode at byte address 0
//
// One word per cycle while out_tready takes the result; a word passes through the
// input register, then the vote and sequencer into the result register.
// The sequencer state moves only when a word passes into the result register.
// A stalled result holds; the input register still takes a word while empty.
// Reset (rst_n, synchronous) clears valids, count, armed, phase, held vote,
// sets the last code to both-on and filter_mode to zero.
module floor_switch_position_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] sample0 .. [15:14] sample7
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] floor_count, [9:8] voted_code,
                                  // [11:10] step_event, [12] armed, rest zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fspt_pkg::*;

  // configuration
  logic mode_r;
  logic cfg_wr;

  // input register
  logic        in_valid_r;
  sample_arr_t samples_r;

  // sequencer state
  logic signed [FLOOR_W-1:0] floor_r, floor_nxt;
  logic                      armed_r, armed_nxt;
  logic [CODE_W-1:0]         last_r, last_nxt;
  logic                      phase_r, phase_nxt;
  logic [CODE_W-1:0]         held_r, held_nxt;

  // result register
  logic                      out_valid_r;
  logic signed [FLOOR_W-1:0] out_floor_r;
  logic [CODE_W-1:0]         out_vote_r;
  logic [EV_W-1:0]           out_ev_r;
  logic                      out_armed_r;

  logic              advance;
  logic              run;
  logic [CODE_W-1:0] vote;
  logic [EV_W-1:0]   ev;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FILTER_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == REG_FILTER_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      samples_r <= sample_arr_t'(in_tdata);
    end
  end

  fspt_vote u_vote (
    .samples (samples_r),
    .vote    (vote)
  );

  always_comb begin
    floor_nxt = floor_r;
    armed_nxt = armed_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    ev        = EV_NONE;
    run       = 1'b0;

    if (!mode_r) begin
      run = 1'b1;
    end else if (!phase_r) begin
      // capture: hold the vote for the next tick
      held_nxt  = vote;
      phase_nxt = 1'b1;
    end else begin
      run       = (vote == held_r);
      phase_nxt = 1'b0;
    end

    if (run) begin
      if (armed_r) begin
        if (vote != CODE_CLEAR && vote != last_r) begin
          if (last_r == CODE_LOWER && vote == CODE_BOTH) begin
            floor_nxt = floor_r + 8'sd1;
            armed_nxt = 1'b0;
            ev        = EV_UP;
          end else if (last_r == CODE_UPPER && vote == CODE_BOTH) begin
            floor_nxt = floor_r - 8'sd1;
            armed_nxt = 1'b0;
            ev        = EV_DOWN;
          end
          last_nxt = vote;
        end
      end else if (vote == CODE_CLEAR) begin
        last_nxt  = CODE_BOTH;
        armed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      armed_r <= 1'b0;
      last_r  <= CODE_BOTH;
      phase_r <= 1'b0;
      held_r  <= CODE_CLEAR;
    end else if (advance) begin
      floor_r <= floor_nxt;
      armed_r <= armed_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_floor_r <= floor_nxt;
      out_vote_r  <= vote;
      out_ev_r    <= ev;
      out_armed_r <= armed_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_armed_r, out_ev_r, out_vote_r, out_floor_r};

`include "assert_macros.svh"

  // a passage always leaves the sequencer disarmed
  `FSPT_ASSERT_NOW(a_step_disarms, out_valid_r && out_ev_r != EV_NONE, !out_armed_r)
  // no event code beyond up and down
  `FSPT_ASSERT_NOW(a_ev_legal, out_valid_r, out_ev_r == EV_NONE || out_ev_r == EV_UP ||
                   out_ev_r == EV_DOWN)
  // an up step moves the count by exactly one
  `FSPT_ASSERT_NEXT(a_up_count, advance && ev == EV_UP, floor_r == $past(floor_r) + 8'sd1)
  // a capture tick in confirm mode never steps
  `FSPT_ASSERT_NEXT(a_capture_quiet, advance && mode_r && !phase_r,
                    out_ev_r == EV_NONE && phase_r)

endmodule
